// ===== rtl/core/iaid_pkg.sv =====
// ----------------------------------------------------------------------------
// iaid_pkg: shared types and codes for the indexed table
// Command and status codes, controller states, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package iaid_pkg;

	// Fixed widths of the command and result fields.
	localparam int CMD_W   = 2;
	localparam int INDEX_W = 6;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_RD_FIN,
		S_INS_SHIFT,
		S_INS_PUT,
		S_DEL_GRAB,
		S_DEL_SHIFT
	} state_t;

	// Source of the word placed in a result.
	typedef enum logic [1:0] {
		RES_ZERO,
		RES_RDATA,
		RES_REMOVED
	} res_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                load;
		logic                rd_pos;
		logic                ptr_ld_cnt;
		logic                ptr_ld_pos1;
		logic                ins_step;
		logic                del_step;
		logic                grab;
		logic                put;
		logic                cnt_inc;
		logic                cnt_dec;
		logic                res_en;
		logic [STAT_W-1:0]   res_status;
		res_sel_t            res_sel;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             ins_range;
		logic             full;
		logic             rd_range;
		logic             ins_more;
		logic             del_more;
	} stat_t;

endpackage

// ===== rtl/core/indexed_array_insert_delete.sv =====
// A done strobe follows each command: an error after the evaluation state, a
// read after S_RD_FIN, an insert after its shift and the put, a delete after
// its grab and shift. Busy drops in the cycle that shows the result, and a
// new command can be taken in that cycle; shifts move one entry per cycle
// through the single write port. The receiver cannot stall.
// Reset clears the live count and the sequencer; entry contents stay unknown.
// ----------------------------------------------------------------------------
// indexed_array_insert_delete: ordered table with insert, append, read, delete
// A table of up to CAPACITY words with a live count, updated by position.
// ----------------------------------------------------------------------------
module indexed_array_insert_delete #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [iaid_pkg::CMD_W-1:0]       command,
	input  logic [iaid_pkg::INDEX_W-1:0]     index,
	input  logic [iaid_pkg::VALUE_W-1:0]     value,
	output logic                             done,
	output logic [iaid_pkg::STAT_W-1:0]      status,
	output logic [iaid_pkg::VALUE_W-1:0]     read_value,
	output logic [iaid_pkg::COUNT_W-1:0]     count
);

	// A command beat is taken when start is high and busy is low. The
	// controller then checks the position against the live count in its
	// evaluation state. Errors report at once and leave the table alone.
	//
	// Insert and append walk a cursor from the top entry down to the target
	// position. Each cycle reads the entry below the cursor, and the word
	// comes back in the next cycle and is written one place higher, so the
	// memory read and write ports overlap and the shift runs one entry per
	// cycle. The new word goes in after the last move has been written.
	//
	// Delete first reads the removed word, then walks upward, writing each
	// entry one place lower in the same overlapped fashion. The result beat
	// carries the removed word and the reduced count.

	iaid_pkg::ctl_t  ctl;
	iaid_pkg::stat_t stat;

	iaid_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.ctl    (ctl)
	);

	iaid_dp #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.command    (command),
		.index      (index),
		.value      (value),
		.done       (done),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

endmodule

// ===== rtl/core/iaid_dp.sv =====
// ----------------------------------------------------------------------------
// iaid_dp: table storage, pointers and result register
// Holds the entry memory, the live count, the latched command, the shift
// pointer with its one-deep write-back stage, and the registered result.
// ----------------------------------------------------------------------------
module iaid_dp #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  iaid_pkg::ctl_t                   ctl,
	output iaid_pkg::stat_t                  stat,
	input  logic [iaid_pkg::CMD_W-1:0]       command,
	input  logic [iaid_pkg::INDEX_W-1:0]     index,
	input  logic [iaid_pkg::VALUE_W-1:0]     value,
	output logic                             done,
	output logic [iaid_pkg::STAT_W-1:0]      status,
	output logic [iaid_pkg::VALUE_W-1:0]     read_value,
	output logic [iaid_pkg::COUNT_W-1:0]     count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > iaid_pkg::INDEX_W) ? CW : iaid_pkg::INDEX_W;
	localparam int WW = (DATA_WIDTH > iaid_pkg::VALUE_W) ? DATA_WIDTH : iaid_pkg::VALUE_W;
	localparam int OW = (CW > iaid_pkg::COUNT_W) ? CW : iaid_pkg::COUNT_W;

	logic [DATA_WIDTH-1:0] mem [CAPACITY];

	logic [iaid_pkg::CMD_W-1:0] cmd_q;
	logic [XW-1:0]              pos_q;
	logic [DATA_WIDTH-1:0]      val_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              ptr_q;
	logic                       pend_q;
	logic [AW-1:0]              pend_addr_q;
	logic [DATA_WIDTH-1:0]      rdata_q;
	logic [DATA_WIDTH-1:0]      rem_q;

	logic                       done_q;
	logic [iaid_pkg::STAT_W-1:0]  res_stat_q;
	logic [iaid_pkg::VALUE_W-1:0] res_val_q;
	logic [iaid_pkg::COUNT_W-1:0] res_cnt_q;

	logic [WW-1:0]         value_ext;
	logic [CW-1:0]         ptr_m1;
	logic [CW-1:0]         cnt_d;
	logic [OW-1:0]         cnt_ext;
	logic [DATA_WIDTH-1:0] res_word;
	logic [WW-1:0]         res_ext;

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;

	assign value_ext = WW'(value);
	assign ptr_m1    = ptr_q - CW'(1);

	assign stat.cmd       = cmd_q;
	assign stat.ins_range = pos_q > XW'(count_q);
	assign stat.full      = count_q == CW'(CAPACITY);
	assign stat.rd_range  = pos_q >= XW'(count_q);
	assign stat.ins_more  = XW'(ptr_q) > pos_q;
	assign stat.del_more  = ptr_q < count_q;

	// Read port: the entry under the cursor, or the commanded position.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pos_q[AW-1:0];
		if (ctl.rd_pos) begin
			rd_en = 1'b1;
		end else if (ctl.ins_step && stat.ins_more) begin
			rd_en   = 1'b1;
			rd_addr = ptr_m1[AW-1:0];
		end else if (ctl.del_step && stat.del_more) begin
			rd_en   = 1'b1;
			rd_addr = ptr_q[AW-1:0];
		end
	end

	// Write port: the new word, or the word read in the previous cycle.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pend_addr_q;
		wr_data = rdata_q;
		if (ctl.put) begin
			wr_en   = 1'b1;
			wr_addr = pos_q[AW-1:0];
			wr_data = val_q;
		end else if (pend_q) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Latched command fields; append takes the count as its position.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			val_q <= value_ext[DATA_WIDTH-1:0];
			if (command == iaid_pkg::CMD_APPEND) begin
				pos_q <= XW'(count_q);
			end else begin
				pos_q <= XW'(index);
			end
		end
		if (ctl.grab) begin
			rem_q <= rdata_q;
		end
	end

	// Shift cursor and the write-back target of the word in flight.
	always_ff @(posedge clk) begin
		if (ctl.ptr_ld_cnt) begin
			ptr_q <= count_q;
		end else if (ctl.ptr_ld_pos1) begin
			ptr_q <= pos_q[CW-1:0] + CW'(1);
		end else if (ctl.ins_step && stat.ins_more) begin
			ptr_q       <= ptr_m1;
			pend_addr_q <= ptr_q[AW-1:0];
		end else if (ctl.del_step && stat.del_more) begin
			ptr_q       <= ptr_q + CW'(1);
			pend_addr_q <= ptr_m1[AW-1:0];
		end
	end

	assign cnt_d   = ctl.cnt_inc ? count_q + CW'(1) :
	                 ctl.cnt_dec ? count_q - CW'(1) : count_q;
	assign cnt_ext = OW'(cnt_d);

	always_comb begin
		case (ctl.res_sel)
			iaid_pkg::RES_RDATA:   res_word = rdata_q;
			iaid_pkg::RES_REMOVED: res_word = rem_q;
			default:               res_word = '0;
		endcase
	end
	assign res_ext = WW'(res_word);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			count_q <= cnt_d;
			pend_q  <= (ctl.ins_step && stat.ins_more) || (ctl.del_step && stat.del_more);
			done_q  <= ctl.res_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.res_en) begin
			res_stat_q <= ctl.res_status;
			res_val_q  <= res_ext[iaid_pkg::VALUE_W-1:0];
			res_cnt_q  <= cnt_ext[iaid_pkg::COUNT_W-1:0];
		end
	end

	assign done       = done_q;
	assign status     = res_stat_q;
	assign read_value = res_val_q;
	assign count      = res_cnt_q;

endmodule

// ===== rtl/core/iaid_ctrl.sv =====
// ----------------------------------------------------------------------------
// iaid_ctrl: command sequencer
// Checks each command against the live count and steps the datapath through
// read, insert shift and delete shift sequences.
// ----------------------------------------------------------------------------
module iaid_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  iaid_pkg::stat_t  stat,
	output iaid_pkg::ctl_t   ctl
);

	iaid_pkg::state_t state_q;
	iaid_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iaid_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != iaid_pkg::S_IDLE;

	always_comb begin
		state_d = state_q;
		case (state_q)
			iaid_pkg::S_IDLE: begin
				if (start) begin
					state_d = iaid_pkg::S_EVAL;
				end
			end
			iaid_pkg::S_EVAL: begin
				case (stat.cmd)
					iaid_pkg::CMD_READ: begin
						state_d = stat.rd_range ? iaid_pkg::S_IDLE : iaid_pkg::S_RD_FIN;
					end
					iaid_pkg::CMD_DELETE: begin
						state_d = stat.rd_range ? iaid_pkg::S_IDLE : iaid_pkg::S_DEL_GRAB;
					end
					default: begin
						state_d = (stat.ins_range || stat.full) ? iaid_pkg::S_IDLE
						                                       : iaid_pkg::S_INS_SHIFT;
					end
				endcase
			end
			iaid_pkg::S_RD_FIN:    state_d = iaid_pkg::S_IDLE;
			iaid_pkg::S_INS_SHIFT: begin
				if (!stat.ins_more) begin
					state_d = iaid_pkg::S_INS_PUT;
				end
			end
			iaid_pkg::S_INS_PUT:   state_d = iaid_pkg::S_IDLE;
			iaid_pkg::S_DEL_GRAB:  state_d = iaid_pkg::S_DEL_SHIFT;
			iaid_pkg::S_DEL_SHIFT: begin
				if (!stat.del_more) begin
					state_d = iaid_pkg::S_IDLE;
				end
			end
			default:               state_d = iaid_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl            = '0;
		ctl.res_status = iaid_pkg::ST_OK;
		ctl.res_sel    = iaid_pkg::RES_ZERO;
		case (state_q)
			iaid_pkg::S_IDLE: begin
				ctl.load = start;
			end
			iaid_pkg::S_EVAL: begin
				case (stat.cmd)
					iaid_pkg::CMD_READ: begin
						if (stat.rd_range) begin
							ctl.res_en     = 1'b1;
							ctl.res_status = iaid_pkg::ST_RANGE;
						end else begin
							ctl.rd_pos = 1'b1;
						end
					end
					iaid_pkg::CMD_DELETE: begin
						if (stat.rd_range) begin
							ctl.res_en     = 1'b1;
							ctl.res_status = iaid_pkg::ST_RANGE;
						end else begin
							ctl.rd_pos      = 1'b1;
							ctl.ptr_ld_pos1 = 1'b1;
						end
					end
					default: begin
						// The index is checked before the fill level.
						if (stat.ins_range) begin
							ctl.res_en     = 1'b1;
							ctl.res_status = iaid_pkg::ST_RANGE;
						end else if (stat.full) begin
							ctl.res_en     = 1'b1;
							ctl.res_status = iaid_pkg::ST_FULL;
						end else begin
							ctl.ptr_ld_cnt = 1'b1;
						end
					end
				endcase
			end
			iaid_pkg::S_RD_FIN: begin
				ctl.res_en  = 1'b1;
				ctl.res_sel = iaid_pkg::RES_RDATA;
			end
			iaid_pkg::S_INS_SHIFT: begin
				ctl.ins_step = 1'b1;
			end
			iaid_pkg::S_INS_PUT: begin
				ctl.put     = 1'b1;
				ctl.cnt_inc = 1'b1;
				ctl.res_en  = 1'b1;
			end
			iaid_pkg::S_DEL_GRAB: begin
				ctl.grab = 1'b1;
			end
			iaid_pkg::S_DEL_SHIFT: begin
				ctl.del_step = 1'b1;
				if (!stat.del_more) begin
					ctl.cnt_dec = 1'b1;
					ctl.res_en  = 1'b1;
					ctl.res_sel = iaid_pkg::RES_REMOVED;
				end
			end
			default: begin
				ctl.load = 1'b0;
			end
		endcase
	end

endmodule

// ===== verif/indexed_array_insert_delete_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_array_insert_delete_tb: self-checking bench for the indexed table
// Drives insert, append, read and delete commands through the start/busy
// handshake and checks every done beat against a behavioral copy of the
// table. A short directed table walks the error paths and the shifts, then
// random fill and drain sequences push the table between empty and full.
// ----------------------------------------------------------------------------
module indexed_array_insert_delete_tb;

	localparam int  TABLE_DEPTH  = 64;
	localparam int  WORD_BITS    = 32;
	localparam real CLK_PERIOD   = 10.0;
	localparam int  RANDOM_ITEMS = 1150;
	// Set far above the length of a correct run, even with the slowest commands
	// and the longest sender gaps.
	localparam int  CYCLE_LIMIT  = 600_000;

	// One result beat as the block presents it.
	typedef struct packed {
		logic [iaid_pkg::STAT_W-1:0]  status;
		logic [iaid_pkg::VALUE_W-1:0] word;
		logic [iaid_pkg::COUNT_W-1:0] fill;
	} table_reply_t;

	// One directed command. When has_reply is set the reply is typed in here;
	// otherwise it comes from the table model and the reply field is unused.
	typedef struct packed {
		logic [iaid_pkg::CMD_W-1:0]   cmd;
		logic [iaid_pkg::INDEX_W-1:0] idx;
		logic [iaid_pkg::VALUE_W-1:0] val;
		logic                         has_reply;
		table_reply_t                 reply;
	} table_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [iaid_pkg::CMD_W-1:0]     command;
	logic [iaid_pkg::INDEX_W-1:0]   index;
	logic [iaid_pkg::VALUE_W-1:0]   value;
	logic                           done;
	logic [iaid_pkg::STAT_W-1:0]    status;
	logic [iaid_pkg::VALUE_W-1:0]   read_value;
	logic [iaid_pkg::COUNT_W-1:0]   count;

	// Behavioral copy of the table contents and its live count.
	logic [iaid_pkg::VALUE_W-1:0]   table_words [TABLE_DEPTH];
	logic [iaid_pkg::COUNT_W-1:0]   live_fill = '0;

	// Replies still owed by the block, oldest first.
	table_reply_t         expected_replies [$];
	int                   error_count = 0;
	int                   cycle_count = 0;

	table_row_t           directed_rows [20];

	indexed_array_insert_delete #(
		.CAPACITY   (TABLE_DEPTH),
		.DATA_WIDTH (WORD_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.index      (index),
		.value      (value),
		.done       (done),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	// Runs one command against the table copy and returns the reply it owes.
	// Inserts move the upper entries up starting from the top one, deletes
	// move them down starting just above the removed position.
	function automatic table_reply_t apply_command(input logic [iaid_pkg::CMD_W-1:0] cmd,
			input logic [iaid_pkg::INDEX_W-1:0] idx,
			input logic [iaid_pkg::VALUE_W-1:0] val);
		table_reply_t reply;
		int           pos;
		int           i;
		reply.status = iaid_pkg::ST_OK;
		reply.word   = '0;
		pos = (cmd == iaid_pkg::CMD_APPEND) ? int'(live_fill) : int'(idx);
		case (cmd)
			iaid_pkg::CMD_INSERT, iaid_pkg::CMD_APPEND: begin
				// The position is checked before the table is found full.
				if (pos > int'(live_fill)) begin
					reply.status = iaid_pkg::ST_RANGE;
				end else if (int'(live_fill) >= TABLE_DEPTH) begin
					reply.status = iaid_pkg::ST_FULL;
				end else begin
					for (i = int'(live_fill); i > pos; i--)
						table_words[i] = table_words[i - 1];
					table_words[pos] = val;
					live_fill++;
				end
			end
			iaid_pkg::CMD_READ: begin
				if (pos >= int'(live_fill))
					reply.status = iaid_pkg::ST_RANGE;
				else
					reply.word = table_words[pos];
			end
			default: begin
				if (pos >= int'(live_fill)) begin
					reply.status = iaid_pkg::ST_RANGE;
				end else begin
					reply.word = table_words[pos];
					for (i = pos; i + 1 < int'(live_fill); i++)
						table_words[i] = table_words[i + 1];
					live_fill--;
				end
			end
		endcase
		reply.fill = live_fill;
		return reply;
	endfunction

	// Data words lean toward all zeros and all ones so both show up often.
	function automatic logic [iaid_pkg::VALUE_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// A position in 0..top, with the two ends picked more often than the rest.
	function automatic logic [iaid_pkg::INDEX_W-1:0] pick_position(input int top);
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return top[iaid_pkg::INDEX_W-1:0];
			default: return iaid_pkg::INDEX_W'($urandom_range(0, top));
		endcase
	endfunction

	function automatic int idle_gap(input int percent);
		if ($urandom_range(0, 99) < percent)
			return $urandom_range(1, 6);
		return 0;
	endfunction

	// Builds one random command. While the table grows most commands are
	// well-formed appends and inserts; while it shrinks most are deletes.
	// Whatever is left over is noise: any command with any position.
	task automatic make_command(input bit growing,
			output logic [iaid_pkg::CMD_W-1:0] cmd,
			output logic [iaid_pkg::INDEX_W-1:0] idx,
			output logic [iaid_pkg::VALUE_W-1:0] val);
		int roll;
		int fill;
		fill = int'(live_fill);
		roll = $urandom_range(0, 99);
		val  = pick_word();
		cmd  = iaid_pkg::CMD_W'($urandom);
		idx  = iaid_pkg::INDEX_W'($urandom);
		if (growing) begin
			if (roll < 40) begin
				cmd = iaid_pkg::CMD_APPEND;
			end else if (roll < 75) begin
				cmd = iaid_pkg::CMD_INSERT;
				idx = pick_position(fill > 63 ? 63 : fill);
			end else if (roll < 85 && fill > 0) begin
				cmd = iaid_pkg::CMD_READ;
				idx = pick_position(fill - 1);
			end else if (roll < 90 && fill > 0) begin
				cmd = iaid_pkg::CMD_DELETE;
				idx = pick_position(fill - 1);
			end
		end else begin
			if (roll < 55 && fill > 0) begin
				cmd = iaid_pkg::CMD_DELETE;
				idx = pick_position(fill - 1);
			end else if (roll < 70 && fill > 0) begin
				cmd = iaid_pkg::CMD_READ;
				idx = pick_position(fill - 1);
			end else if (roll < 80) begin
				cmd = $urandom_range(0, 1) ? iaid_pkg::CMD_APPEND : iaid_pkg::CMD_INSERT;
				idx = pick_position(fill > 63 ? 63 : fill);
			end
		end
	endtask

	// Presents one command beat, optionally after some idle cycles, and holds it
	// until the block takes it. Inputs only move at falling edges. On return we
	// sit on a falling edge with start still high, so a back-to-back beat keeps
	// start asserted without ever touching it twice in one time step.
	task automatic send_command(input logic [iaid_pkg::CMD_W-1:0] cmd,
			input logic [iaid_pkg::INDEX_W-1:0] idx,
			input logic [iaid_pkg::VALUE_W-1:0] val,
			input int gap, input bit fixed, input table_reply_t fixed_reply);
		table_reply_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start   <= 1'b1;
		command <= cmd;
		index   <= idx;
		value   <= val;
		do @(posedge clk); while (busy !== 1'b0);
		// The beat was taken at this edge; the table copy moves on with it.
		predicted = apply_command(cmd, idx, val);
		expected_replies.push_back(fixed ? fixed_reply : predicted);
		@(negedge clk);
	endtask

	// Drops start and waits until every owed reply has come back. Always waits
	// for a falling edge first so start is not written twice at once.
	task automatic drain_replies();
		start <= 1'b0;
		do @(negedge clk); while (expected_replies.size() != 0);
	endtask

	// Result checker. A done beat can never be dropped, so every beat seen at a
	// rising edge is compared with the oldest owed reply.
	always @(posedge clk) begin
		table_reply_t want;
		if (arst_n === 1'b1 && done !== 1'b0) begin
			if (expected_replies.size() == 0) begin
				$error("result beat with none owed: status %0d word %h count %0d",
					status, read_value, count);
				error_count++;
			end else begin
				want = expected_replies.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					error_count++;
				end
				if (read_value !== want.word) begin
					$error("read_value: expected %h, got %h", want.word, read_value);
					error_count++;
				end
				if (count !== want.fill) begin
					$error("count: expected %0d, got %0d", want.fill, count);
					error_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake or a lost beat ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [iaid_pkg::CMD_W-1:0]   cmd;
		logic [iaid_pkg::INDEX_W-1:0] idx;
		logic [iaid_pkg::VALUE_W-1:0] val;
		bit                           growing;
		int                           idle_pct;
		int                           n;

		arst_n  = 1'b0;
		start   = 1'b0;
		command = iaid_pkg::CMD_READ;
		index   = '0;
		value   = '0;

		// Directed commands, starting from an empty table. Rows with a typed
		// reply are the error cases, the first insert and the two appends; the shifted
		// inserts, reads and deletes are left to the table copy.
		directed_rows = '{
			// Reads and deletes on an empty table, and inserts past its end, are out of range.
			'{iaid_pkg::CMD_READ, 6'd0, 32'h0, 1'b1, '{iaid_pkg::ST_RANGE, 32'h0, 7'd0}},
			'{iaid_pkg::CMD_DELETE, 6'd63, 32'h0, 1'b1, '{iaid_pkg::ST_RANGE, 32'h0, 7'd0}},
			'{iaid_pkg::CMD_INSERT, 6'd1, 32'hFFFF_FFFF, 1'b1,
				'{iaid_pkg::ST_RANGE, 32'h0, 7'd0}},
			'{iaid_pkg::CMD_INSERT, 6'd63, 32'h0, 1'b1, '{iaid_pkg::ST_RANGE, 32'h0, 7'd0}},
			// Insert at position equal to the count, then appends that ignore
			// whatever position is given.
			'{iaid_pkg::CMD_INSERT, 6'd0, 32'hFFFF_FFFF, 1'b1,
				'{iaid_pkg::ST_OK, 32'h0, 7'd1}},
			'{iaid_pkg::CMD_APPEND, 6'd63, 32'h0, 1'b1, '{iaid_pkg::ST_OK, 32'h0, 7'd2}},
			'{iaid_pkg::CMD_APPEND, 6'd0, 32'h1234_5678, 1'b1,
				'{iaid_pkg::ST_OK, 32'h0, 7'd3}},
			// Inserts at the bottom, in the middle and at the top.
			'{iaid_pkg::CMD_INSERT, 6'd0, 32'hA5A5_A5A5, 1'b0,
				'{iaid_pkg::ST_OK, 32'h0, 7'd0}},
			'{iaid_pkg::CMD_INSERT, 6'd2, 32'h5A5A_5A5A, 1'b0,
				'{iaid_pkg::ST_OK, 32'h0, 7'd0}},
			'{iaid_pkg::CMD_INSERT, 6'd5, 32'h0F0F_0F0F, 1'b0,
				'{iaid_pkg::ST_OK, 32'h0, 7'd0}},
			'{iaid_pkg::CMD_READ, 6'd0, 32'hFFFF_FFFF, 1'b0, '{iaid_pkg::ST_OK, 32'h0, 7'd0}},
			'{iaid_pkg::CMD_READ, 6'd5, 32'h0, 1'b0, '{iaid_pkg::ST_OK, 32'h0, 7'd0}},
			// Reads and deletes at or past the count leave the table alone.
			'{iaid_pkg::CMD_READ, 6'd6, 32'h0, 1'b1, '{iaid_pkg::ST_RANGE, 32'h0, 7'd6}},
			'{iaid_pkg::CMD_READ, 6'd63, 32'h0, 1'b1, '{iaid_pkg::ST_RANGE, 32'h0, 7'd6}},
			'{iaid_pkg::CMD_DELETE, 6'd6, 32'h0, 1'b1, '{iaid_pkg::ST_RANGE, 32'h0, 7'd6}},
			// Deletes at the bottom, at the top and in the middle.
			'{iaid_pkg::CMD_DELETE, 6'd0, 32'h0, 1'b0, '{iaid_pkg::ST_OK, 32'h0, 7'd0}},
			'{iaid_pkg::CMD_DELETE, 6'd4, 32'h0, 1'b0, '{iaid_pkg::ST_OK, 32'h0, 7'd0}},
			'{iaid_pkg::CMD_DELETE, 6'd1, 32'h0, 1'b0, '{iaid_pkg::ST_OK, 32'h0, 7'd0}},
			// Insert two places past the last entry of a three-entry table.
			'{iaid_pkg::CMD_INSERT, 6'd4, 32'hDEAD_BEEF, 1'b1,
				'{iaid_pkg::ST_RANGE, 32'h0, 7'd3}},
			'{iaid_pkg::CMD_READ, 6'd2, 32'h0, 1'b0, '{iaid_pkg::ST_OK, 32'h0, 7'd0}}
		};

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[k])
			send_command(directed_rows[k].cmd, directed_rows[k].idx, directed_rows[k].val,
				idle_gap(21), directed_rows[k].has_reply, directed_rows[k].reply);

		// Random part in three stretches: light sender idling, heavy idling,
		// then back-to-back beats. Between stretches the sender stops until
		// every owed reply has come, so the block also starts from idle.
		// The table is filled until it reports full a few times, then drained
		// until reads and deletes run out of range, and so on.
		growing = 1'b1;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3)
				drain_replies();
			idle_pct = (n < RANDOM_ITEMS / 3) ? 21 : (n < 2 * RANDOM_ITEMS / 3) ? 73 : 0;
			make_command(growing, cmd, idx, val);
			send_command(cmd, idx, val, idle_gap(idle_pct), 1'b0, '0);
			if (growing && int'(live_fill) == TABLE_DEPTH && $urandom_range(0, 3) == 0)
				growing = 1'b0;
			else if (!growing && live_fill == '0 && $urandom_range(0, 2) == 0)
				growing = 1'b1;
		end

		// Wait for the last replies, then give any stray beat time to show.
		drain_replies();
		repeat (TABLE_DEPTH + 8) @(negedge clk);

		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/iaid_pkg.sv
rtl/core/iaid_dp.sv
rtl/core/iaid_ctrl.sv
rtl/core/indexed_array_insert_delete.sv
verif/indexed_array_insert_delete_tb.sv
